// File: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared widths, codes and control structs for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int DATA_W          = 32;
	localparam int COUNT_W         = 5;
	localparam int STATUS_W        = 2;
	localparam int OP_W            = 2;
	localparam int STACK_DEPTH_DEF = 16;

	// one shift-add / shift-subtract step per operand bit
	localparam int STEPS = DATA_W;
	localparam int CNT_W = $clog2(STEPS);

	// item kinds
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_CALC = 1'b1;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;
	localparam logic [OP_W-1:0] OP_DIV = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FEW  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd3;

	// request into the arithmetic unit
	typedef struct packed {
		logic            start;
		logic [OP_W-1:0] op;
	} alu_req_t;

	// response from the arithmetic unit
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

endpackage

// File: rtl/rpn_in_if.sv
// ----------------------------------------------------------------------------
// rpn_in_if
// Input channel: one push or calc word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpn_in_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [rpn_pkg::DATA_W-1:0]   value;
	logic        [rpn_pkg::OP_W-1:0]     op;

	modport source (output valid, output kind, output value, output op, input ready);
	modport sink   (input valid, input kind, input value, input op, output ready);
endinterface

// File: rtl/rpn_out_if.sv
// ----------------------------------------------------------------------------
// rpn_out_if
// Output channel: one result word per input word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpn_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rpn_pkg::DATA_W-1:0]   top_value;
	logic        [rpn_pkg::COUNT_W-1:0]  stack_count;
	logic        [rpn_pkg::STATUS_W-1:0] status;

	modport source (output valid, output top_value, output stack_count, output status,
		input ready);
	modport sink   (input valid, input top_value, input stack_count, input status,
		output ready);
endinterface

// File: rtl/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Shared arithmetic unit around a single 33-bit adder. Add and subtract
// finish without iterating; multiply (shift-add) and signed divide (restoring,
// on magnitudes) take one step per bit.
// ----------------------------------------------------------------------------
module rpn_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpn_pkg::alu_req_t             req,
	input  logic [rpn_pkg::DATA_W-1:0]    lhs,
	input  logic [rpn_pkg::DATA_W-1:0]    rhs,
	output rpn_pkg::alu_rsp_t             rsp
);

	localparam int W = rpn_pkg::DATA_W;

	logic                       busy_q;
	logic                       done_q;
	logic [rpn_pkg::CNT_W-1:0]  cnt_q;
	logic [rpn_pkg::OP_W-1:0]   op_q;
	logic                       neg_q;
	logic [W-1:0]               acc_q;   // product / partial remainder
	logic [W-1:0]               x_q;     // multiplicand / divisor
	logic [W-1:0]               y_q;     // multiplier / dividend-quotient
	logic [W-1:0]               res_q;

	logic [W:0]                 add_a;
	logic [W:0]                 add_b;
	logic                       add_cin;
	logic [W+1:0]               sum;
	logic                       qbit;
	logic [W-1:0]               qmag;
	logic [W-1:0]               lhs_mag;
	logic [W-1:0]               rhs_mag;
	logic                       last_step;

	// shared adder operand select
	always_comb begin
		add_a   = {1'b0, lhs};
		add_b   = {1'b0, rhs};
		add_cin = 1'b0;
		if (busy_q) begin
			if (op_q == rpn_pkg::OP_DIV) begin
				add_a   = {acc_q, y_q[W-1]};
				add_b   = ~{1'b0, x_q};
				add_cin = 1'b1;
			end else begin
				add_a = {1'b0, acc_q};
				add_b = y_q[0] ? {1'b0, x_q} : '0;
			end
		end else if (req.op == rpn_pkg::OP_SUB) begin
			add_b   = ~{1'b0, rhs};
			add_cin = 1'b1;
		end
	end

	assign sum       = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, add_cin};
	assign qbit      = sum[W+1];                 // no borrow: divisor fits
	assign qmag      = {y_q[W-2:0], qbit};
	assign lhs_mag   = lhs[W-1] ? (~lhs + 1'b1) : lhs;
	assign rhs_mag   = rhs[W-1] ? (~rhs + 1'b1) : rhs;
	assign last_step = (cnt_q == rpn_pkg::CNT_W'(rpn_pkg::STEPS - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				done_q <= last_step;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end else if (req.start) begin
				cnt_q <= '0;
				if (req.op == rpn_pkg::OP_MUL || req.op == rpn_pkg::OP_DIV) begin
					busy_q <= 1'b1;
					done_q <= 1'b0;
				end else begin
					done_q <= 1'b1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (op_q == rpn_pkg::OP_DIV) begin
				acc_q <= qbit ? sum[W-1:0] : add_a[W-1:0];
				y_q   <= qmag;
				if (last_step) begin
					res_q <= neg_q ? (~qmag + 1'b1) : qmag;
				end
			end else begin
				acc_q <= sum[W-1:0];
				x_q   <= {x_q[W-2:0], 1'b0};
				y_q   <= {1'b0, y_q[W-1:1]};
				if (last_step) begin
					res_q <= sum[W-1:0];
				end
			end
		end else if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			neg_q <= lhs[W-1] ^ rhs[W-1];
			res_q <= sum[W-1:0];
			if (req.op == rpn_pkg::OP_DIV) begin
				x_q <= rhs_mag;
				y_q <= lhs_mag;
			end else begin
				x_q <= lhs;
				y_q <= rhs;
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// File: rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Stack calculator on 32-bit signed words with a shared iterative ALU.
// ----------------------------------------------------------------------------
// Accept to result valid: a push or a refused calc goes straight to finish;
// a calc reads its left operand, waits on the ALU, then finishes. One word in
// flight; the next word is taken the cycle after the result is registered,
// mul/div bound by the 32 shift-add/subtract steps of the shared ALU. Top of
// stack lives in a register; lower entries sit in a one-read-port memory.
// Reset (arst_n low) empties the stack and drops any pending result.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rpn_in_if.sink      req,
	rpn_out_if.source   rsp
);

	localparam int W    = rpn_pkg::DATA_W;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int AW   = $clog2(STACK_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]                     state_q;
	logic [SP_W-1:0]                sp_q;
	logic [W-1:0]                   top_q;
	logic [rpn_pkg::OP_W-1:0]       op_q;
	logic [rpn_pkg::STATUS_W-1:0]   status_q;
	logic                           ovalid_q;
	logic [W-1:0]                   otop_q;
	logic [rpn_pkg::COUNT_W-1:0]    ocount_q;
	logic [rpn_pkg::STATUS_W-1:0]   ostatus_q;

	logic [W-1:0]                   mem [STACK_DEPTH];
	logic [W-1:0]                   rd_q;
	logic                           mem_we;
	logic [AW-1:0]                  waddr;
	logic [AW-1:0]                  raddr;
	logic [SP_W-1:0]                sp_m1;
	logic [SP_W-1:0]                sp_m2;

	logic                           accept;
	logic                           is_full;
	logic                           few;
	logic                           out_free;

	rpn_pkg::alu_req_t              alu_req;
	rpn_pkg::alu_rsp_t              alu_rsp;

	assign accept   = req.valid && req.ready;
	assign is_full  = (sp_q == SP_W'(STACK_DEPTH));
	assign few      = (sp_q < SP_W'(2));
	assign out_free = !ovalid_q || rsp.ready;
	assign sp_m1    = sp_q - 1'b1;
	assign sp_m2    = sp_q - SP_W'(2);
	assign waddr    = sp_m1[AW-1:0];
	assign raddr    = sp_m2[AW-1:0];

	// old top spills into memory on a push
	assign mem_we = accept && (req.kind == rpn_pkg::KIND_PUSH) && !is_full
		&& (sp_q != '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= top_q;
		end
		rd_q <= mem[raddr];
	end

	// shared arithmetic unit: left from memory, right from top register
	assign alu_req.start = (state_q == S_RD);
	assign alu_req.op    = op_q;

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (rd_q),
		.rhs    (top_q),
		.rsp    (alu_rsp)
	);

	// sequencer and stack control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.kind == rpn_pkg::KIND_PUSH) begin
							state_q <= S_FIN;
							if (!is_full) begin
								sp_q <= sp_q + 1'b1;
							end
						end else if (few || (req.op == rpn_pkg::OP_DIV && top_q == '0)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						sp_q    <= sp_m1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// top register, op and status
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.op;
			if (req.kind == rpn_pkg::KIND_PUSH) begin
				if (is_full) begin
					status_q <= rpn_pkg::ST_FULL;
				end else begin
					status_q <= rpn_pkg::ST_OK;
					top_q    <= req.value;
				end
			end else if (few) begin
				status_q <= rpn_pkg::ST_FEW;
			end else if (req.op == rpn_pkg::OP_DIV && top_q == '0) begin
				status_q <= rpn_pkg::ST_DIV0;
			end else begin
				status_q <= rpn_pkg::ST_OK;
			end
		end else if (state_q == S_WAIT && alu_rsp.done) begin
			top_q <= alu_rsp.result;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			otop_q    <= (sp_q == '0) ? '0 : top_q;
			ocount_q  <= rpn_pkg::COUNT_W'(sp_q);
			ostatus_q <= status_q;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = ovalid_q;
	assign rsp.top_value   = otop_q;
	assign rsp.stack_count = ocount_q;
	assign rsp.status      = ostatus_q;

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_WAIT)
		else $error("ALU result outside wait state");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == rpn_pkg::KIND_PUSH && !is_full)
		|=> sp_q == $past(sp_q) + 1'b1)
		else $error("push did not grow stack");

endmodule
